// ===== src/owned_resource_table_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Owned resource table assertion macros
// Shorthand for the concurrent assertions of the port checker.
// ----------------------------------------------------------------------------
`ifndef OWNED_RESOURCE_TABLE_UNIT_MACROS_SVH
`define OWNED_RESOURCE_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ORTU_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ortu assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ORTU_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ortu assertion failed");

`endif

// ===== src/ortu_pkg.sv =====
// ----------------------------------------------------------------------------
// Owned resource table package
// Shared widths, command and outcome codes, and controller handshake types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ortu_pkg;

  localparam int TABLE_ENTRIES_DEFAULT = 64;

  localparam int CMD_W   = 2;
  localparam int INDEX_W = 16;
  localparam int KIND_W  = 4;
  localparam int OWNER_W = 8;
  localparam int OUTC_W  = 2;

  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  localparam logic [OUTC_W-1:0] OUT_DONE    = 2'd0;
  localparam logic [OUTC_W-1:0] OUT_PRESENT = 2'd1;
  localparam logic [OUTC_W-1:0] OUT_FULL    = 2'd2;
  localparam logic [OUTC_W-1:0] OUT_MISSING = 2'd3;

  typedef struct packed {
    logic start;
    logic scan;
    logic commit;
  } ortu_ctrl_t;

  typedef struct packed {
    logic last_addr;
    logic out_free;
  } ortu_stat_t;

endpackage

// ===== src/ortu_req_if.sv =====
// ----------------------------------------------------------------------------
// Owned resource table request channel
// Valid/ready channel carrying one command beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ortu_req_if
  import ortu_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [INDEX_W-1:0] resource_index;
  logic [KIND_W-1:0]  resource_type;
  logic [OWNER_W-1:0] owner_id;

  modport source (output valid, command, resource_index, resource_type, owner_id,
                  input ready);
  modport sink (input valid, command, resource_index, resource_type, owner_id,
                output ready);
endinterface

// ===== src/ortu_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Owned resource table response channel
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ortu_rsp_if
  import ortu_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              answer;
  logic [OUTC_W-1:0] outcome;

  modport source (output valid, answer, outcome, input ready);
  modport sink (input valid, answer, outcome, output ready);
endinterface

// ===== src/ortu_ctrl.sv =====
// ----------------------------------------------------------------------------
// Owned resource table controller
// Sequences accept, table scan, compare drain and commit of one command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ortu_ctrl
  import ortu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  ortu_stat_t stat,
  output ortu_ctrl_t ctrl
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign req_ready = (state == ST_IDLE);

  always_comb begin
    state_next  = state;
    ctrl.start  = 1'b0;
    ctrl.scan   = 1'b0;
    ctrl.commit = 1'b0;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          ctrl.start = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ctrl.scan = 1'b1;
        if (stat.last_addr) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          ctrl.commit = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== src/ortu_datapath.sv =====
// ----------------------------------------------------------------------------
// Owned resource table datapath
// Entry memory, occupancy bits, scan compare, table update and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ortu_datapath
  import ortu_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  ortu_ctrl_t         ctrl,
  output ortu_stat_t         stat,
  input  logic [CMD_W-1:0]   command,
  input  logic [INDEX_W-1:0] resource_index,
  input  logic [KIND_W-1:0]  resource_type,
  input  logic [OWNER_W-1:0] owner_id,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               answer,
  output logic [OUTC_W-1:0]  outcome
);

  localparam int AW      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int ENTRY_W = KIND_W + INDEX_W + OWNER_W;

  logic [ENTRY_W-1:0] mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] occ;

  logic [CMD_W-1:0]   req_cmd;
  logic [INDEX_W-1:0] req_index;
  logic [KIND_W-1:0]  req_kind;
  logic [OWNER_W-1:0] req_owner;

  logic [AW-1:0]      addr;
  logic               cmp_valid;
  logic [ENTRY_W-1:0] rd_entry;
  logic               rd_occ;
  logic [AW-1:0]      rd_slot;

  logic               found;
  logic               others;
  logic               have_free;
  logic [AW-1:0]      hit_slot;
  logic [AW-1:0]      free_slot;

  logic [KIND_W-1:0]  rd_kind;
  logic [INDEX_W-1:0] rd_index;
  logic [OWNER_W-1:0] rd_owner;
  logic               rd_hit;
  logic               add_write;
  logic               rem_clear;
  logic               res_answer;
  logic [OUTC_W-1:0]  res_outcome;

  assign rd_kind  = rd_entry[ENTRY_W-1 -: KIND_W];
  assign rd_index = rd_entry[OWNER_W +: INDEX_W];
  assign rd_owner = rd_entry[OWNER_W-1:0];
  assign rd_hit   = rd_occ && (rd_kind == req_kind) && (rd_index == req_index);

  assign add_write = (req_cmd == CMD_ADD) && !found && have_free;
  assign rem_clear = (req_cmd == CMD_REMOVE) && found;

  assign stat.last_addr = (addr == AW'(TABLE_ENTRIES - 1));
  assign stat.out_free  = !out_valid || out_ready;

  always_comb begin
    res_answer  = 1'b0;
    res_outcome = OUT_MISSING;
    case (req_cmd)
      CMD_ADD: begin
        if (found) begin
          res_outcome = OUT_PRESENT;
        end else if (have_free) begin
          res_outcome = OUT_DONE;
        end else begin
          res_outcome = OUT_FULL;
        end
      end
      CMD_REMOVE: begin
        res_answer  = !others;
        res_outcome = found ? OUT_DONE : OUT_MISSING;
      end
      CMD_QUERY: begin
        res_answer  = found || others;
        res_outcome = (found || others) ? OUT_DONE : OUT_MISSING;
      end
      default: begin
        res_answer  = 1'b0;
        res_outcome = OUT_MISSING;
      end
    endcase
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (ctrl.commit && add_write) begin
      mem[free_slot] <= {req_kind, req_index, req_owner};
    end
    rd_entry <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr      <= '0;
      cmp_valid <= 1'b0;
      out_valid <= 1'b0;
      occ       <= '0;
    end else begin
      if (ctrl.start) begin
        addr <= '0;
      end else if (ctrl.scan) begin
        addr <= addr + 1'b1;
      end
      cmp_valid <= ctrl.scan;
      if (ctrl.commit) begin
        if (add_write) begin
          occ[free_slot] <= (req_kind != '0);
        end else if (rem_clear) begin
          occ[hit_slot] <= 1'b0;
        end
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_occ  <= occ[addr];
    rd_slot <= addr;
    if (ctrl.start) begin
      req_cmd   <= command;
      req_index <= resource_index;
      req_kind  <= resource_type;
      req_owner <= owner_id;
      found     <= 1'b0;
      others    <= 1'b0;
      have_free <= 1'b0;
    end else if (cmp_valid) begin
      if (rd_hit && (rd_owner == req_owner)) begin
        found    <= 1'b1;
        hit_slot <= rd_slot;
      end
      if (rd_hit && (rd_owner != req_owner)) begin
        others <= 1'b1;
      end
      if (!rd_occ) begin
        have_free <= 1'b1;
        free_slot <= rd_slot;
      end
    end
    if (ctrl.commit) begin
      answer  <= res_answer;
      outcome <= res_outcome;
    end
  end

endmodule

// ===== src/owned_resource_table_unit.sv =====
// ----------------------------------------------------------------------------
// Owned resource table unit
// Table of owned resource entries with add, remove and query commands.
// ----------------------------------------------------------------------------
// Each command runs from acceptance through the table scan back to idle:
// the table sits in a memory with one registered read port, so the scan
// reads one entry per cycle, followed by the compare of the last entry,
// the table update and load of the result register (held back while the
// previous result has not been taken), and the return to idle to accept
// the next beat. The result register holds a finished beat while the next
// command is accepted and scanned. After reset every entry is free at
// once; no clearing pass is needed.
`timescale 1ns / 1ps

module owned_resource_table_unit
  import ortu_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  ortu_req_if.sink   request,
  ortu_rsp_if.source response
);

  ortu_ctrl_t ctrl;
  ortu_stat_t stat;

  ortu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_ready (request.ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  ortu_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .stat           (stat),
    .command        (request.command),
    .resource_index (request.resource_index),
    .resource_type  (request.resource_type),
    .owner_id       (request.owner_id),
    .out_valid      (response.valid),
    .out_ready      (response.ready),
    .answer         (response.answer),
    .outcome        (response.outcome)
  );

endmodule

// ===== src/ortu_checker.sv =====
// ----------------------------------------------------------------------------
// Owned resource table port checker
// Watches the request and response ports of the table unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "owned_resource_table_unit_macros.svh"

module ortu_checker
  import ortu_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic              rsp_answer,
  input logic [OUTC_W-1:0] rsp_outcome
);

  `ORTU_ASSERT_NEXT(a_busy_after_accept, clk, rst, req_valid && req_ready, !req_ready)
  `ORTU_ASSERT_IMPL(a_answer_clear_on_add, clk, rst,
    rsp_valid && (rsp_outcome == OUT_PRESENT || rsp_outcome == OUT_FULL), !rsp_answer)
  `ORTU_ASSERT_NEXT(a_rsp_valid_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid)
  `ORTU_ASSERT_NEXT(a_rsp_payload_hold, clk, rst, rsp_valid && !rsp_ready,
    $stable(rsp_answer) && $stable(rsp_outcome))

endmodule

bind owned_resource_table_unit ortu_checker u_ortu_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (request.valid),
  .req_ready   (request.ready),
  .rsp_valid   (response.valid),
  .rsp_ready   (response.ready),
  .rsp_answer  (response.answer),
  .rsp_outcome (response.outcome)
);
